FILE: rtl/tta_pkg.sv
// Shared types and constants of the tick time accumulator.
package tta_pkg;

  // Divider geometry: the widest dividend is the measured frame time.
  localparam int unsigned DivW     = 24;
  localparam int unsigned DvsW     = 16;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  // Field widths.
  localparam int unsigned MsW      = 32;
  localparam int unsigned RemW     = 10;
  localparam int unsigned TickW    = 16;
  localparam int unsigned TargetW  = 11;
  localparam int unsigned SumW     = 17;
  localparam int unsigned OutDataW = 96;

  // Microseconds in one millisecond, and the saturation limit of 16-bit values.
  localparam logic [DvsW-1:0]  UsPerMs = 16'd1000;
  localparam logic [TickW-1:0] Max16   = 16'hFFFF;

  // Event kinds carried in tuser.
  localparam logic OpTick  = 1'b0;
  localparam logic OpFrame = 1'b1;

  // Configuration register indexes.
  localparam logic CfgTargetPeriod = 1'b0;
  localparam logic CfgPeriodUnit   = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  // Request and response of the shared serial divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DvsW-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/tta_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tta_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tta_pkg::div_req_t req_i,
  output tta_pkg::div_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tta_pkg::StepCntW-1:0]   step_q, step_d;
  logic [tta_pkg::DivW-1:0]       quo_q, quo_d;
  logic [tta_pkg::DvsW-1:0]       rem_q, rem_d;
  logic [tta_pkg::DvsW-1:0]       dvs_q, dvs_d;
  logic [tta_pkg::DvsW:0]         trial;
  logic [tta_pkg::DvsW+1:0]       diff;

  // One step: bring down the next dividend bit and try a subtraction.
  assign trial = {rem_q, quo_q[tta_pkg::DivW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = tta_pkg::StepCntW'(tta_pkg::DivSteps - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (diff[tta_pkg::DvsW+1]) begin
        rem_d = trial[tta_pkg::DvsW-1:0];
        quo_d = {quo_q[tta_pkg::DivW-2:0], 1'b0};
      end else begin
        rem_d = diff[tta_pkg::DvsW-1:0];
        quo_d = {quo_q[tta_pkg::DivW-2:0], 1'b1};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // Control state is reset; the data path is loaded on start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/tick_time_accumulator_top.sv
// Top level of the tick time accumulator: event sequencer, counters and result register.
//
// Each event word (tuser: 0 timer tick, 1 frame start) returns one result word with the
// counters after the update. A timer tick and a frame start after at least one tick both
// pass through the shared bit-serial divider, 24 steps: the sequencer waits in ST_DIV
// until the divider is done, loads the result in ST_COMMIT once the result register is
// free, and can accept the next word in the cycle after the load. A frame start with no
// tick in the frame needs no division: it goes straight to ST_COMMIT, where its result
// is loaded once the result register is free. The divider sets the rate, one event at a
// time; the next word is taken as soon as the result is loaded, even while it waits.
module tick_time_accumulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  // Event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] frame_micros
  input  logic        s_axis_tuser,   // [0] op
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [31:0] frame_ms, [63:32] total_ms,
                                      // [73:64] remainder_us, [89:74] tick_us, [95:90] zero
);

  tta_pkg::state_e state_q, state_d;

  logic [tta_pkg::TargetW-1:0]  target_q;
  logic                         unit_q;
  logic [tta_pkg::MsW-1:0]      frame_ms_q, frame_ms_d;
  logic [tta_pkg::MsW-1:0]      total_ms_q, total_ms_d;
  logic [tta_pkg::RemW-1:0]     rem_q, rem_d;
  logic [tta_pkg::TickW-1:0]    tick_us_q, tick_us_d;
  logic [tta_pkg::TickW-1:0]    tick_cnt_q, tick_cnt_d;
  logic                         op_q;

  logic                         m_tvalid_q, m_tvalid_d;
  logic [tta_pkg::OutDataW-1:0] m_tdata_q;

  logic                         in_acc;
  logic                         need_div;
  logic                         out_free;
  logic                         out_load;
  logic [tta_pkg::SumW-1:0]     sum;
  logic                         carry;
  logic [20:0]                  target_ms_us;
  logic [tta_pkg::TickW-1:0]    target_us;
  logic [tta_pkg::TickW-1:0]    quo_sat;

  tta_pkg::div_req_t            div_req;
  tta_pkg::div_rsp_t            div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= tta_pkg::TargetW'(1);
      unit_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tta_pkg::CfgTargetPeriod: target_q <= cfg_data_i;
        tta_pkg::CfgPeriodUnit:   unit_q   <= cfg_data_i[0];
        default:                  target_q <= target_q;
      endcase
    end
  end

  // Remainder plus the tick credit; only a sum above one millisecond is carried.
  assign sum   = {7'b0, rem_q} + {1'b0, tick_us_q};
  assign carry = sum > {1'b0, tta_pkg::UsPerMs};

  // Target in microseconds: times 1000 is times 1024 less times 24.
  assign target_ms_us = ({target_q, 10'b0}) - ({6'b0, target_q, 4'b0}) - ({7'b0, target_q, 3'b0});
  assign target_us    = !unit_q ? {5'b0, target_q} :
                        (target_ms_us[20:16] != '0) ? tta_pkg::Max16 : target_ms_us[15:0];

  // Saturated frame-time quotient.
  assign quo_sat = (div_rsp.quotient[tta_pkg::DivW-1:tta_pkg::TickW] != '0) ?
                   tta_pkg::Max16 : div_rsp.quotient[tta_pkg::TickW-1:0];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign need_div = (s_axis_tuser == tta_pkg::OpTick) || (tick_cnt_q != '0);
  assign out_free = !m_tvalid_q || m_axis_tready;

  // Divider request: a tick divides the sum by 1000, a frame start the time by the ticks.
  always_comb begin
    div_req.start = in_acc && need_div;
    if (s_axis_tuser == tta_pkg::OpTick) begin
      div_req.dividend = tta_pkg::DivW'(sum);
      div_req.divisor  = tta_pkg::UsPerMs;
    end else begin
      div_req.dividend = s_axis_tdata;
      div_req.divisor  = tick_cnt_q;
    end
  end

  tta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tta_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = need_div ? tta_pkg::ST_DIV : tta_pkg::ST_COMMIT;
        end
      end
      tta_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = tta_pkg::ST_COMMIT;
        end
      end
      tta_pkg::ST_COMMIT: begin
        if (out_free) begin
          state_d = tta_pkg::ST_IDLE;
        end
      end
      default: state_d = tta_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      tta_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      tta_pkg::ST_DIV:    s_axis_tready = 1'b0;
      tta_pkg::ST_COMMIT: out_load      = out_free;
      default:            s_axis_tready = 1'b0;
    endcase
  end

  // Counter updates, applied when the result is loaded.
  always_comb begin
    frame_ms_d = frame_ms_q;
    total_ms_d = total_ms_q;
    rem_d      = rem_q;
    tick_us_d  = tick_us_q;
    tick_cnt_d = tick_cnt_q;
    if (op_q == tta_pkg::OpTick) begin
      if (tick_cnt_q != tta_pkg::Max16) begin
        tick_cnt_d = tick_cnt_q + 1'b1;
      end
      if (carry) begin
        rem_d      = div_rsp.remainder[tta_pkg::RemW-1:0];
        frame_ms_d = frame_ms_q + tta_pkg::MsW'(div_rsp.quotient);
        total_ms_d = total_ms_q + tta_pkg::MsW'(div_rsp.quotient);
      end else begin
        rem_d = sum[tta_pkg::RemW-1:0];
      end
    end else begin
      frame_ms_d = '0;
      rem_d      = '0;
      tick_us_d  = (tick_cnt_q == '0) ? target_us : quo_sat;
      tick_cnt_d = '0;
    end
  end

  // Result register: freed as soon as the word is taken.
  always_comb begin
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end else begin
      m_tvalid_d = m_tvalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tta_pkg::ST_IDLE;
      frame_ms_q <= '0;
      total_ms_q <= '0;
      rem_q      <= '0;
      tick_us_q  <= tta_pkg::UsPerMs;
      tick_cnt_q <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
      if (out_load) begin
        frame_ms_q <= frame_ms_d;
        total_ms_q <= total_ms_d;
        rem_q      <= rem_d;
        tick_us_q  <= tick_us_d;
        tick_cnt_q <= tick_cnt_d;
      end
    end
  end

  // Event kind and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= s_axis_tuser;
    end
    if (out_load) begin
      m_tdata_q <= {6'b0, tick_us_d, rem_d, total_ms_d, frame_ms_d};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // The carried remainder never exceeds one millisecond.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= tta_pkg::RemW'(tta_pkg::UsPerMs))
    else $error("remainder above one millisecond");

  // The divider is never restarted while it is working.
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !div_req.start)
    else $error("divider restarted while busy");

  // A frame start clears the per-frame milliseconds and the remainder in its result.
  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && op_q == tta_pkg::OpFrame) |=>
      (m_axis_tdata[31:0] == '0 && m_axis_tdata[73:64] == '0))
    else $error("frame start left counters set");

  // After a tick the frame tick count is nonzero.
  a_tick_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && op_q == tta_pkg::OpTick) |=> tick_cnt_q != '0)
    else $error("tick not counted");

endmodule
